[hdl/multi_modulus_rolling_hash_core_defines.svh]
// assertion macros for the rolling hash core checker
// used by mmrh_check only
`ifndef MULTI_MODULUS_ROLLING_HASH_CORE_DEFINES_SVH
`define MULTI_MODULUS_ROLLING_HASH_CORE_DEFINES_SVH

// same-cycle implication, checked on every clock out of reset
`define MMRH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMRH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mmrh_pkg.sv]
// shared types and constants of the rolling hash core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmrh_pkg;

    localparam int HW  = 30;    // width of one lane value
    localparam int HWL = 4;     // lanes built in hardware

    localparam logic [HW-1:0] LANE_MUL [HWL] = '{30'd1007, 30'd1009, 30'd1013, 30'd1001};
    localparam logic [HW-1:0] LANE_MOD [HWL] =
        '{30'd1000000007, 30'd1000000023, 30'd1000000087, 30'd1000000093};

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_QUERY   = 2'd1,
        MODE_COMPARE = 2'd2,
        MODE_CLEAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MUL,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

[hdl/mmrh_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mmrh_ram #(
    parameter int WIDTH = 120,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/mmrh_modmul.sv]
// bit-serial modular multiplier, one bit of b per cycle, msb first
// depends on mmrh_pkg; needs a < m
`timescale 1ns / 1ps
`default_nettype none

module mmrh_modmul
    import mmrh_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [HW-1:0] i_a,
    input  wire logic [HW-1:0] i_b,
    input  wire logic [HW-1:0] i_m,
    output logic               o_done,
    output logic      [HW-1:0] o_prod
);

    localparam int CW = $clog2(HW);

    logic          r_run;
    logic [CW-1:0] r_cnt;
    logic [HW-1:0] r_acc;
    logic [HW-1:0] r_a;
    logic [HW-1:0] r_b;

    logic [HW:0]   dbl;
    logic [HW-1:0] dbl_red;
    logic [HW:0]   sum;
    logic [HW-1:0] n_acc;

    // acc = 2*acc + bit*a, each add reduced once
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? HW'(dbl - {1'b0, i_m}) : HW'(dbl);
        sum     = {1'b0, dbl_red} + (r_b[HW-1] ? {1'b0, r_a} : '0);
        n_acc   = (sum >= {1'b0, i_m}) ? HW'(sum - {1'b0, i_m}) : HW'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            r_run <= 1'b1;
        end else if (r_run && r_cnt == CW'(HW - 1)) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= '0;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[HW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = !r_run;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[hdl/multi_modulus_rolling_hash_core.sv]
// rolling hash core: prefix and power memories, per-lane serial multipliers
// depends on mmrh_pkg, mmrh_ram, mmrh_modmul
// clear and rejected items are answered in the next cycle; append steps through S_RD0,
// S_MUL and S_FIN, query and compare through S_RD0 to S_RD3, S_MUL and S_FIN; the serial
// modular multipliers take one bit per cycle; range reads go one address per cycle through
// the single read port of each memory; one word per cycle for clear and rejected items,
// while append, query and compare hold busy high; busy is low again in the strobe cycle
// reset: synchronous, active low, clears length and control; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module multi_modulus_rolling_hash_core
    import mmrh_pkg::*;
#(
    parameter int MAX_LENGTH = 65535,
    parameter int LANES      = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_mode,
    input  wire logic [29:0]   i_symbol,
    input  wire logic [15:0]   i_first_start,
    input  wire logic [15:0]   i_first_end,
    input  wire logic [15:0]   i_second_start,
    input  wire logic [15:0]   i_second_end,
    output logic               o_valid,
    output logic      [29:0]   o_hash_lane_a,
    output logic      [29:0]   o_hash_lane_b,
    output logic      [29:0]   o_hash_lane_c,
    output logic      [29:0]   o_hash_lane_d,
    output logic               o_ranges_equal,
    output logic      [1:0]    o_status,
    output logic      [15:0]   o_stored_length
);

    localparam int DEPTH = MAX_LENGTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 16;
    localparam int MW    = LANES * HW;

    t_state        r_state, n_state;
    t_mode         r_mode;
    t_status       r_status;
    logic [15:0]   r_r1, r_l2, r_r2;
    logic [HW-1:0] r_sym;
    logic [AW-1:0] r_len;
    logic          r_valid;
    logic          r_eq;
    logic          r_zp, r_zw;

    logic [AW-1:0] p_raddr, w_raddr, waddr;
    logic [MW-1:0] p_rdata, w_rdata, p_wdata, w_wdata;
    logic          mem_we;
    logic          mm_start;
    logic [HWL-1:0] lane_done;
    logic [LANES-1:0] lane_eq;
    logic [HW-1:0] lane_hash [HWL];

    logic [15:0]   span1, span2, span_r;
    logic          ok1, ok2, full;

    always_comb begin
        span1  = i_first_end - i_first_start;
        span2  = r_r2 - r_l2;
        span_r = 16'(r_len);
        ok1    = (i_first_start <= i_first_end) && (CW'(i_first_end) <= CW'(r_len));
        ok2    = (i_second_start <= i_second_end) && (CW'(i_second_end) <= CW'(r_len));
        full   = (CW'(r_len) == CW'(MAX_LENGTH));
    end

    assign waddr = AW'(r_len + 1'b1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        p_raddr  = '0;
        w_raddr  = '0;
        mem_we   = 1'b0;
        mm_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        MODE_APPEND: begin
                            if (!full) begin
                                p_raddr = r_len;
                                w_raddr = r_len;
                                n_state = S_RD0;
                            end
                        end
                        MODE_QUERY: begin
                            if (ok1) begin
                                p_raddr = AW'(i_first_start);
                                w_raddr = AW'(span1);
                                n_state = S_RD0;
                            end
                        end
                        MODE_COMPARE: begin
                            if (ok1 && ok2) begin
                                p_raddr = AW'(i_first_start);
                                w_raddr = AW'(span1);
                                n_state = S_RD0;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD0: begin
                if (r_mode == MODE_APPEND) begin
                    mm_start = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    p_raddr = AW'(r_l2);
                    w_raddr = AW'(span2);
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                p_raddr = AW'(r_r1);
                n_state = S_RD2;
            end
            S_RD2: begin
                p_raddr = AW'(r_r2);
                n_state = S_RD3;
            end
            S_RD3: begin
                mm_start = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                if (lane_done[0]) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                mem_we  = (r_mode == MODE_APPEND);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // clear and rejected words answer at once, the rest after the final step
            r_valid <= ((r_state == S_IDLE) && start && (n_state == S_IDLE))
                       || (r_state == S_FIN);
            if (r_state == S_IDLE && start && t_mode'(i_mode) == MODE_CLEAR) begin
                r_len <= '0;
            end
            if (r_state == S_FIN && r_mode == MODE_APPEND) begin
                r_len <= waddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // address zero is never written: it reads as the reset entry
        r_zp <= (p_raddr == '0);
        r_zw <= (w_raddr == '0);
        if (r_state == S_IDLE && start) begin
            r_mode   <= t_mode'(i_mode);
            r_sym    <= i_symbol;
            r_r1     <= i_first_end;
            r_l2     <= i_second_start;
            r_r2     <= i_second_end;
            r_eq     <= 1'b0;
            case (t_mode'(i_mode))
                MODE_APPEND:  r_status <= full ? ST_FULL : ST_OK;
                MODE_QUERY:   r_status <= ok1 ? ST_OK : ST_RANGE;
                MODE_COMPARE: r_status <= (ok1 && ok2) ? ST_OK : ST_RANGE;
                default:      r_status <= ST_OK;
            endcase
        end
        if (r_state == S_FIN) begin
            r_eq <= (r_mode == MODE_COMPARE) && (&lane_eq);
        end
    end

    mmrh_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    mmrh_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    for (genvar g = 0; g < HWL; g++) begin : g_lane
        if (g < LANES) begin : g_on
            logic [HW-1:0] pv, wv;
            logic [HW-1:0] r_pa, r_wa, r_pb, r_wb, r_h1, r_h2, r_symr, r_hout;
            logic [HW-1:0] a0, b0, a1, b1, prod0, prod1;
            logic          done1;
            logic [HW:0]   psum;
            logic [HW-1:0] np, h1, h2;

            assign pv = r_zp ? '0 : p_rdata[g*HW +: HW];
            assign wv = r_zw ? HW'(1) : w_rdata[g*HW +: HW];

            always_comb begin
                if (r_mode == MODE_APPEND) begin
                    a0 = pv;
                    b0 = LANE_MUL[g];
                    a1 = wv;
                    b1 = LANE_MUL[g];
                end else begin
                    a0 = r_pa;
                    b0 = r_wa;
                    a1 = r_pb;
                    b1 = r_wb;
                end
                psum = {1'b0, prod0} + {1'b0, r_symr};
                np   = (psum >= {1'b0, LANE_MOD[g]}) ? HW'(psum - {1'b0, LANE_MOD[g]})
                                                     : HW'(psum);
                // prefix[hi] - prefix[lo]*power[hi-lo], wrapped into the modulus
                h1   = (r_h1 >= prod0) ? (r_h1 - prod0) : (r_h1 + (LANE_MOD[g] - prod0));
                h2   = (r_h2 >= prod1) ? (r_h2 - prod1) : (r_h2 + (LANE_MOD[g] - prod1));
            end

            mmrh_modmul u_mul0 (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (mm_start),
                .i_a     (a0),
                .i_b     (b0),
                .i_m     (LANE_MOD[g]),
                .o_done  (lane_done[g]),
                .o_prod  (prod0)
            );

            mmrh_modmul u_mul1 (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (mm_start),
                .i_a     (a1),
                .i_b     (b1),
                .i_m     (LANE_MOD[g]),
                .o_done  (done1),
                .o_prod  (prod1)
            );

            always_ff @(posedge i_clk) begin
                case (r_state)
                    S_IDLE: begin
                        if (start) begin
                            r_hout <= '0;
                        end
                    end
                    S_RD0: begin
                        r_pa   <= pv;
                        r_wa   <= wv;
                        r_symr <= (r_sym >= LANE_MOD[g]) ? (r_sym - LANE_MOD[g]) : r_sym;
                    end
                    S_RD1: begin
                        r_pb <= pv;
                        r_wb <= wv;
                    end
                    S_RD2: r_h1 <= pv;
                    S_RD3: r_h2 <= pv;
                    S_FIN: r_hout <= (r_mode == MODE_APPEND) ? '0 : h1;
                    default: r_hout <= r_hout;
                endcase
            end

            assign p_wdata[g*HW +: HW] = np;
            assign w_wdata[g*HW +: HW] = prod1;
            assign lane_eq[g]          = (h1 == h2) && done1;
            assign lane_hash[g]        = r_hout;
        end else begin : g_off
            assign lane_hash[g] = '0;
            assign lane_done[g] = 1'b1;
        end
    end

    assign o_valid         = r_valid;
    assign o_hash_lane_a   = lane_hash[0];
    assign o_hash_lane_b   = lane_hash[1];
    assign o_hash_lane_c   = lane_hash[2];
    assign o_hash_lane_d   = lane_hash[3];
    assign o_ranges_equal  = r_eq;
    assign o_status        = r_status;
    assign o_stored_length = span_r;

endmodule

`default_nettype wire

[hdl/mmrh_check.sv]
// port-level checker for the rolling hash core, bound to the top level
// depends on mmrh_pkg and multi_modulus_rolling_hash_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "multi_modulus_rolling_hash_core_defines.svh"

module mmrh_check
    import mmrh_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_mode,
    input wire logic        o_valid,
    input wire logic [29:0] o_hash_lane_a,
    input wire logic [29:0] o_hash_lane_b,
    input wire logic [29:0] o_hash_lane_c,
    input wire logic [29:0] o_hash_lane_d,
    input wire logic        o_ranges_equal,
    input wire logic [1:0]  o_status,
    input wire logic [15:0] o_stored_length
);

    // a clear word is answered next cycle with an empty store
    `MMRH_ASSERT_NEXT(a_clear_resp, start && !busy && i_mode == MODE_CLEAR, o_valid && o_stored_length == 16'd0 && o_status == ST_OK, "clear not answered with empty store")

    // a rejected word carries no hash and no match
    `MMRH_ASSERT_NOW(a_reject_zero, o_valid && o_status != ST_OK, o_hash_lane_a == 30'd0 && o_hash_lane_b == 30'd0 && o_hash_lane_c == 30'd0 && o_hash_lane_d == 30'd0 && !o_ranges_equal, "rejected word has nonzero fields")

    // a match is only reported for an accepted word
    `MMRH_ASSERT_NOW(a_eq_ok, o_valid && o_ranges_equal, o_status == ST_OK, "match with error status")

    // results do not come two in a row unless start was high with the first one
    `MMRH_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid || $past(start), "result strobe repeated")

endmodule

bind multi_modulus_rolling_hash_core mmrh_check u_check (.*);

`default_nettype wire

[tb/testbench.sv]
// testbench of the four-lane rolling hash core: random and directed items, checked word by word
// against a behavioral model of the prefix and power stores; depends on mmrh_pkg and the core
`timescale 1ns / 1ps

module testbench;
    import mmrh_pkg::*;

    localparam int MAXLEN = 65535;

    typedef struct packed {
        t_mode       mode;
        logic [29:0] symbol;
        logic [15:0] l1, r1, l2, r2;
    } t_item;

    typedef struct packed {
        logic [29:0] ha, hb, hc, hd;
        logic        eq;
        t_status     status;
        logic [15:0] len;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_mode = '0;
    logic [29:0] i_symbol = '0;
    logic [15:0] i_first_start = '0, i_first_end = '0, i_second_start = '0, i_second_end = '0;
    logic        o_valid;
    logic [29:0] o_hash_lane_a, o_hash_lane_b, o_hash_lane_c, o_hash_lane_d;
    logic        o_ranges_equal;
    logic [1:0]  o_status;
    logic [15:0] o_stored_length;

    multi_modulus_rolling_hash_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model stores
    logic [29:0] prefix_mem [HWL][MAXLEN+1];
    logic [29:0] power_mem  [HWL][MAXLEN+1];
    int unsigned seq_len;

    t_item   pending_words[$];
    t_result expected_words[$];
    int      error_count = 0;
    bit      hold_sender = 0;
    bit      quiet_tail = 0;
    int      send_gap = 0;

    function automatic logic [29:0] span_hash(int lane, int unsigned lo, int unsigned hi);
        longint unsigned m, sub;
        m = LANE_MOD[lane];
        sub = (longint'(prefix_mem[lane][lo]) * power_mem[lane][hi-lo]) % m;
        return 30'((prefix_mem[lane][hi] + m - sub) % m);
    endfunction

    function automatic t_result hash_store_step(t_item it);
        t_result         r;
        longint unsigned m, v;
        logic [29:0]     h [HWL];
        r = '0;
        for (int k = 0; k < HWL; k++) h[k] = '0;
        case (it.mode)
            MODE_APPEND: begin
                if (seq_len >= MAXLEN) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = 0; k < HWL; k++) begin
                        m = LANE_MOD[k];
                        v = (longint'(prefix_mem[k][seq_len]) * LANE_MUL[k]) % m;
                        v = (v + it.symbol % m) % m;
                        prefix_mem[k][seq_len+1] = 30'(v);
                        power_mem[k][seq_len+1] =
                            30'((longint'(power_mem[k][seq_len]) * LANE_MUL[k]) % m);
                    end
                    seq_len++;
                end
            end
            MODE_QUERY: begin
                if (it.l1 > it.r1 || it.r1 > seq_len) r.status = ST_RANGE;
                else for (int k = 0; k < HWL; k++) h[k] = span_hash(k, it.l1, it.r1);
            end
            MODE_COMPARE: begin
                if (it.l1 > it.r1 || it.r1 > seq_len || it.l2 > it.r2 || it.r2 > seq_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.eq = 1'b1;
                    for (int k = 0; k < HWL; k++) begin
                        h[k] = span_hash(k, it.l1, it.r1);
                        if (h[k] != span_hash(k, it.l2, it.r2)) r.eq = 1'b0;
                    end
                end
            end
            default: seq_len = 0;
        endcase
        r.ha = h[0]; r.hb = h[1]; r.hc = h[2]; r.hd = h[3];
        r.len = 16'(seq_len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (start && !busy) begin
                start <= 1'b0;
            end else if (!start) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (!hold_sender && pending_words.size() > 0) begin
                    it = pending_words.pop_front();
                    expected_words.push_back(hash_store_step(it));
                    start          <= 1'b1;
                    i_mode         <= it.mode;
                    i_symbol       <= it.symbol;
                    i_first_start  <= it.l1;
                    i_first_end    <= it.r1;
                    i_second_start <= it.l2;
                    i_second_end   <= it.r2;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 14);
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                w = expected_words.pop_front();
                if (o_hash_lane_a != w.ha) report_mismatch("hash_lane_a", o_hash_lane_a, w.ha);
                if (o_hash_lane_b != w.hb) report_mismatch("hash_lane_b", o_hash_lane_b, w.hb);
                if (o_hash_lane_c != w.hc) report_mismatch("hash_lane_c", o_hash_lane_c, w.hc);
                if (o_hash_lane_d != w.hd) report_mismatch("hash_lane_d", o_hash_lane_d, w.hd);
                if (o_ranges_equal != w.eq) report_mismatch("ranges_equal", o_ranges_equal, w.eq);
                if (o_status != w.status) report_mismatch("status", o_status, w.status);
                if (o_stored_length != w.len)
                    report_mismatch("stored_length", o_stored_length, w.len);
            end
        end
    end

    function automatic t_item make_item(t_mode md, logic [29:0] s, int a, int b, int c, int d);
        t_item it;
        it.mode = md; it.symbol = s;
        it.l1 = 16'(a); it.r1 = 16'(b); it.l2 = 16'(c); it.r2 = 16'(d);
        return it;
    endfunction

    // pick a range mostly inside the stored sequence
    task automatic pick_span(int unsigned n, output int lo, output int hi);
        if ($urandom_range(0, 9) == 0) begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
        end else begin
            hi = $urandom_range(0, n);
            lo = $urandom_range(0, hi);
        end
    endtask

    task automatic queue_random(int count);
        int unsigned n;
        int a, b, c, d;
        logic [29:0] s;
        n = seq_len;
        for (int k = 0; k < count; k++) begin
            pick_span(n, a, b);
            pick_span(n, c, d);
            // repeated symbol patterns make equal ranges likely
            s = ($urandom_range(0, 3) == 0) ? 30'($urandom_range(0, 2)) : 30'($urandom());
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    pending_words.push_back(make_item(MODE_APPEND, s, a, b, c, d));
                    if (n < MAXLEN) n++;
                end
                8, 9, 10, 11, 12: pending_words.push_back(make_item(MODE_QUERY, s, a, b, c, d));
                13, 14, 15, 16, 17: begin
                    if ($urandom_range(0, 2) == 0 && b - a <= n) begin
                        c = $urandom_range(0, n - (b - a));
                        d = c + (b - a);
                    end
                    pending_words.push_back(make_item(MODE_COMPARE, s, a, b, c, d));
                end
                18: pending_words.push_back(make_item(MODE_CLEAR, s, a, b, c, d));
                default: begin
                    if (n > 40) begin
                        pending_words.push_back(make_item(MODE_CLEAR, s, a, b, c, d));
                        n = 0;
                    end else begin
                        pending_words.push_back(make_item(MODE_QUERY, s, a, b, c, d));
                    end
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < HWL; k++) begin
            prefix_mem[k][0] = '0;
            power_mem[k][0] = 30'd1;
        end
        seq_len = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queries, symbols at and beyond the moduli, equal and unequal ranges
        pending_words.push_back(make_item(MODE_QUERY, '0, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_QUERY, '0, 0, 1, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'd0, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'h3FFFFFFF, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'd1000000006, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'd1000000093, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'd0, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'h3FFFFFFF, 0, 0, 0, 0));
        pending_words.push_back(make_item(MODE_QUERY, '0, 0, 6, 0, 0));
        pending_words.push_back(make_item(MODE_QUERY, '0, 3, 3, 0, 0));
        pending_words.push_back(make_item(MODE_QUERY, '0, 4, 2, 0, 0));
        pending_words.push_back(make_item(MODE_QUERY, '0, 65535, 65535, 0, 0));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 0, 2, 4, 6));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 0, 2, 1, 3));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 1, 1, 5, 5));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 0, 3, 0, 7));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 3, 2, 0, 1));
        pending_words.push_back(make_item(MODE_CLEAR, 30'h3FFFFFFF, 16'hFFFF, 16'hFFFF,
                                          16'hFFFF, 16'hFFFF));
        pending_words.push_back(make_item(MODE_QUERY, '0, 0, 1, 0, 0));
        pending_words.push_back(make_item(MODE_APPEND, 30'd5, 0, 0, 0, 0));
        wait_drained();

        // sender holds while a batch of items is queued, then releases it
        hold_sender = 1;
        queue_random(20);
        repeat (5) @(posedge i_clk);
        hold_sender = 0;
        wait_drained();

        for (int blk = 0; blk < 10; blk++) begin
            queue_random(100);
            wait_drained();
        end

        // ranges at the top of the position space
        pending_words.push_back(make_item(MODE_QUERY, '0, 0, 65535, 0, 0));
        pending_words.push_back(make_item(MODE_COMPARE, '0, 0, 65535, 1, 65535));
        pending_words.push_back(make_item(MODE_QUERY, '0, 65535, 65535, 0, 0));
        pending_words.push_back(make_item(MODE_CLEAR, '0, 0, 0, 0, 0));
        wait_drained();
        quiet_tail = 1;
        queue_random(60);
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("multi_modulus_rolling_hash_core test passed");
        end else begin
            $display("multi_modulus_rolling_hash_core test failed");
        end
        $finish;
    end

    // roughly 1100 items in all, with a wide margin
    initial begin
        #5ms;
        $display("multi_modulus_rolling_hash_core test failed");
        $finish;
    end

endmodule
